@@ rtl/core/bsp_pkg.sv @@
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types, register indexes and reset values of the sprite projection.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int FRAC_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAYER_X      = 4'd0,
        CFG_PLAYER_Y      = 4'd1,
        CFG_DIR_X         = 4'd2,
        CFG_DIR_Y         = 4'd3,
        CFG_PLANE_X       = 4'd4,
        CFG_PLANE_Y       = 4'd5,
        CFG_SCREEN_WIDTH  = 4'd6,
        CFG_SCREEN_HEIGHT = 4'd7
    } cfg_idx_t;

    localparam logic [23:0] PLAYER_X_RST      = 24'd0;
    localparam logic [23:0] PLAYER_Y_RST      = 24'd0;
    localparam logic [15:0] DIR_X_RST         = 16'd16384;
    localparam logic [15:0] DIR_Y_RST         = 16'd0;
    localparam logic [15:0] PLANE_X_RST       = 16'd0;
    localparam logic [15:0] PLANE_Y_RST       = 16'd10813;
    localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic signed [23:0] sprite_x;
        logic signed [23:0] sprite_y;
    } sprite_t;

    typedef struct packed {
        logic signed [31:0] depth;
        logic signed [15:0] screen_center_x;
        logic        [15:0] sprite_size;
        logic        [14:0] start_x;
        logic signed [15:0] end_x;
        logic        [14:0] start_y;
        logic signed [15:0] end_y;
        logic               behind_camera;
        logic               singular_camera;
    } result_t;

endpackage

@@ rtl/core/bsp_div.sv @@
// ----------------------------------------------------------------------------
// bsp_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with
// quotient overflow detection and a sideband that travels with each item.
// ----------------------------------------------------------------------------
module bsp_div #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int QB = 16,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] in_side,
    output logic          out_valid,
    output logic [QB-1:0] quo,
    output logic          ovf,
    output logic [PW-1:0] out_side
);

    localparam int CW = (NW > DW) ? NW : DW;

    logic          valid_reg [QB+1];
    logic [DW-1:0] rem_reg   [QB+1];
    logic [QB-1:0] low_reg   [QB+1];
    logic [QB-1:0] quo_reg   [QB+1];
    logic [DW-1:0] den_reg   [QB+1];
    logic          ovf_reg   [QB+1];
    logic [PW-1:0] side_reg  [QB+1];

    logic [NW-1:0] hi;
    logic [CW-1:0] hi_ext;

    // If the upper part of the numerator is below the divisor, the quotient
    // fits in QB bits and that upper part is the starting remainder.
    assign hi     = num >> QB;
    assign hi_ext = CW'(hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= hi_ext[DW-1:0];
            low_reg[0]  <= num[QB-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= (hi_ext >= CW'(den));
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        logic [DW:0]   trial;
        logic          fits;
        logic [DW:0]   diff;

        assign trial = {rem_reg[k-1], low_reg[k-1][QB-1]};
        assign fits  = (trial >= {1'b0, den_reg[k-1]});
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= fits ? diff[DW-1:0] : trial[DW-1:0];
                low_reg[k]  <= low_reg[k-1] << 1;
                quo_reg[k]  <= (quo_reg[k-1] << 1) | QB'(fits);
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign quo       = quo_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign out_side  = side_reg[QB];

endmodule

@@ rtl/core/billboard_sprite_projection.sv @@
// ----------------------------------------------------------------------------
// billboard_sprite_projection
// Projects a sprite's map position into camera space and screen bounds.
// ----------------------------------------------------------------------------
// The block takes one sprite item per clock while sprite_stall is low and
// returns one result per sprite, in order, through three pipelined restoring
// dividers: the depth divider (33 stages) runs first, then the center-column
// and size dividers (17 stages each) run side by side. A result-side stall
// freezes the whole pipeline, passed back as sprite_stall. Camera registers
// must be written only while no item is in flight; the block does not check.
module billboard_sprite_projection #(
    parameter int FRAC_BITS = bsp_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sprite_valid,
    output logic                                sprite_stall,
    input  bsp_pkg::sprite_t                    sprite,
    output logic                                result_valid,
    input  logic                                result_stall,
    output bsp_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bsp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SHIFT  = 30 - FRAC_BITS;
    localparam int NUM1_W = 42 + SHIFT;
    localparam int N2W    = 55;
    localparam int D2W    = 42;
    localparam int PA_W   = 4 + N2W + D2W;

    // ---------------- configuration ----------------
    logic signed [23:0] player_x_reg, player_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic        [12:0] screen_width_reg, screen_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg      <= bsp_pkg::PLAYER_X_RST;
            player_y_reg      <= bsp_pkg::PLAYER_Y_RST;
            dir_x_reg         <= bsp_pkg::DIR_X_RST;
            dir_y_reg         <= bsp_pkg::DIR_Y_RST;
            plane_x_reg       <= bsp_pkg::PLANE_X_RST;
            plane_y_reg       <= bsp_pkg::PLANE_Y_RST;
            screen_width_reg  <= bsp_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= bsp_pkg::SCREEN_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (bsp_pkg::cfg_idx_t'(cfg_index))
                bsp_pkg::CFG_PLAYER_X:      player_x_reg      <= cfg_data;
                bsp_pkg::CFG_PLAYER_Y:      player_y_reg      <= cfg_data;
                bsp_pkg::CFG_DIR_X:         dir_x_reg         <= cfg_data[15:0];
                bsp_pkg::CFG_DIR_Y:         dir_y_reg         <= cfg_data[15:0];
                bsp_pkg::CFG_PLANE_X:       plane_x_reg       <= cfg_data[15:0];
                bsp_pkg::CFG_PLANE_Y:       plane_y_reg       <= cfg_data[15:0];
                bsp_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[12:0];
                bsp_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[12:0];
                default:                    ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v8_reg;
    logic va_out, vb_out, vc_out;

    assign en           = !(result_valid && result_stall);
    assign sprite_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v8_reg       <= 1'b0;
            result_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg       <= sprite_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
            v6_reg       <= va_out;
            v8_reg       <= vb_out && vc_out;
            result_valid <= v8_reg;
        end
    end

    // ---------------- stages 1 to 5: transform ----------------
    logic signed [24:0] sx1_reg, sy1_reg;
    logic signed [31:0] pd1_reg, pd2_reg;
    logic signed [40:0] m_dysx2_reg, m_dxsy2_reg, m_plxsy2_reg, m_plysx2_reg;
    logic signed [32:0] det2_reg, det3_reg;
    logic signed [41:0] nx3_reg, ny3_reg;
    logic signed [42:0] nsum4_reg;
    logic        [41:0] nyabs4_reg;
    logic        [31:0] detabs4_reg;
    logic               ny_neg4_reg, sign1_4_reg, det_zero4_reg, ny_zero4_reg;
    logic [NUM1_W-1:0]  num1_5_reg;
    logic        [31:0] den1_5_reg;
    logic [N2W-1:0]     num2_5_reg;
    logic [D2W-1:0]     den2_5_reg;
    logic               sign1_5_reg, sign2_5_reg, det_zero5_reg, ny_zero5_reg;
    logic        [42:0] nsum_abs;
    logic        [11:0] half;

    assign half     = screen_width_reg[12:1];
    assign nsum_abs = nsum4_reg[42] ? 43'(-nsum4_reg) : 43'(nsum4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx1_reg <= 25'(sprite.sprite_x) - 25'(player_x_reg);
            sy1_reg <= 25'(sprite.sprite_y) - 25'(player_y_reg);
            pd1_reg <= plane_x_reg * dir_y_reg;
            pd2_reg <= dir_x_reg * plane_y_reg;

            m_dysx2_reg  <= dir_y_reg * sx1_reg;
            m_dxsy2_reg  <= dir_x_reg * sy1_reg;
            m_plxsy2_reg <= plane_x_reg * sy1_reg;
            m_plysx2_reg <= plane_y_reg * sx1_reg;
            det2_reg     <= 33'(pd1_reg) - 33'(pd2_reg);

            nx3_reg  <= 42'(m_dysx2_reg) - 42'(m_dxsy2_reg);
            ny3_reg  <= 42'(m_plxsy2_reg) - 42'(m_plysx2_reg);
            det3_reg <= det2_reg;

            nsum4_reg     <= 43'(ny3_reg) + 43'(nx3_reg);
            nyabs4_reg    <= ny3_reg[41] ? 42'(-ny3_reg) : 42'(ny3_reg);
            detabs4_reg   <= det3_reg[32] ? 32'(-det3_reg) : 32'(det3_reg);
            ny_neg4_reg   <= ny3_reg[41];
            sign1_4_reg   <= ny3_reg[41] ^ det3_reg[32];
            det_zero4_reg <= (det3_reg == '0);
            ny_zero4_reg  <= (ny3_reg == '0);

            num1_5_reg    <= {NUM1_W'(nyabs4_reg)} << SHIFT;
            den1_5_reg    <= detabs4_reg;
            num2_5_reg    <= N2W'(half) * N2W'(nsum_abs);
            den2_5_reg    <= nyabs4_reg;
            sign1_5_reg   <= sign1_4_reg;
            sign2_5_reg   <= nsum4_reg[42] ^ ny_neg4_reg;
            det_zero5_reg <= det_zero4_reg;
            ny_zero5_reg  <= ny_zero4_reg;
        end
    end

    // ---------------- depth divider ----------------
    logic [31:0]   qa;
    logic          ovfa;
    logic [PA_W-1:0] side_a;

    bsp_div #(
        .NW (NUM1_W),
        .DW (32),
        .QB (32),
        .PW (PA_W)
    ) u_div_depth (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .num       (num1_5_reg),
        .den       (den1_5_reg),
        .in_side   ({sign1_5_reg, det_zero5_reg, ny_zero5_reg, sign2_5_reg,
                     num2_5_reg, den2_5_reg}),
        .out_valid (va_out),
        .quo       (qa),
        .ovf       (ovfa),
        .out_side  (side_a)
    );

    // ---------------- stage 6: saturate depth ----------------
    logic               a_sign1, a_det_zero, a_ny_zero, a_sign2;
    logic [N2W-1:0]     a_num2;
    logic [D2W-1:0]     a_den2;
    logic               depth_big;
    logic signed [31:0] depth6_reg;
    logic        [31:0] adepth6_reg;
    logic               behind6_reg, det_zero6_reg, ny_zero6_reg, sign2_6_reg;
    logic [N2W-1:0]     num2_6_reg;
    logic [D2W-1:0]     den2_6_reg;

    assign {a_sign1, a_det_zero, a_ny_zero, a_sign2, a_num2, a_den2} = side_a;
    assign depth_big = a_sign1 ? (ovfa || (qa > 32'h8000_0000))
                               : (ovfa || qa[31]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (a_sign1)
            begin
                depth6_reg  <= depth_big ? 32'sh8000_0000 : 32'(-qa);
                adepth6_reg <= depth_big ? 32'h8000_0000 : qa;
            end
            else
            begin
                depth6_reg  <= depth_big ? 32'sh7fff_ffff : qa;
                adepth6_reg <= depth_big ? 32'h7fff_ffff : qa;
            end
            // A zero or negative exact quotient puts the sprite behind.
            behind6_reg   <= a_sign1 || (!ovfa && (qa == '0));
            det_zero6_reg <= a_det_zero;
            ny_zero6_reg  <= a_ny_zero;
            sign2_6_reg   <= a_sign2;
            num2_6_reg    <= a_num2;
            den2_6_reg    <= a_den2;
        end
    end

    // ---------------- center and size dividers ----------------
    logic [15:0] qb, qc;
    logic        ovfb, ovfc;
    logic [1:0]  side_b;
    logic [33:0] side_c;

    bsp_div #(
        .NW (N2W),
        .DW (D2W),
        .QB (16),
        .PW (2)
    ) u_div_center (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .num       (num2_6_reg),
        .den       (den2_6_reg),
        .in_side   ({sign2_6_reg, ny_zero6_reg}),
        .out_valid (vb_out),
        .quo       (qb),
        .ovf       (ovfb),
        .out_side  (side_b)
    );

    // A zero depth divides by zero, which the overflow flag turns into the
    // saturated size.
    bsp_div #(
        .NW (29),
        .DW (32),
        .QB (16),
        .PW (34)
    ) u_div_size (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .num       ({screen_height_reg, 16'd0}),
        .den       (adepth6_reg),
        .in_side   ({depth6_reg, behind6_reg, det_zero6_reg}),
        .out_valid (vc_out),
        .quo       (qc),
        .ovf       (ovfc),
        .out_side  (side_c)
    );

    // ---------------- stage 8: saturate center and size ----------------
    logic               b_sign2, b_ny_zero, center_big;
    logic signed [15:0] center8_reg;
    logic        [15:0] size8_reg;
    logic signed [31:0] depth8_reg;
    logic               behind8_reg, det_zero8_reg;

    assign {b_sign2, b_ny_zero} = side_b;
    assign center_big = b_sign2 ? (ovfb || (qb > 16'h8000)) : (ovfb || qb[15]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (b_ny_zero)
            begin
                center8_reg <= 16'(half);
            end
            else if (b_sign2)
            begin
                center8_reg <= center_big ? 16'sh8000 : 16'(-qb);
            end
            else
            begin
                center8_reg <= center_big ? 16'sh7fff : qb;
            end
            size8_reg     <= ovfc ? 16'hffff : qc;
            depth8_reg    <= side_c[33:2];
            behind8_reg   <= side_c[1];
            det_zero8_reg <= side_c[0];
        end
    end

    // ---------------- stage 9: bounds and output register ----------------
    logic        [14:0] s2;
    logic signed [17:0] cx_lo, cx_hi, wm1, y_lo, y_hi, hm1;
    bsp_pkg::result_t   res_next;

    assign s2    = size8_reg[15:1];
    assign cx_lo = 18'(center8_reg) - $signed({3'b000, s2});
    assign cx_hi = 18'(center8_reg) + $signed({3'b000, s2});
    assign wm1   = $signed({5'b00000, screen_width_reg}) - 18'sd1;
    assign y_lo  = $signed({6'b000000, screen_height_reg[12:1]}) - $signed({3'b000, s2});
    assign y_hi  = $signed({6'b000000, screen_height_reg[12:1]}) + $signed({3'b000, s2});
    assign hm1   = $signed({5'b00000, screen_height_reg}) - 18'sd1;

    always_comb
    begin
        res_next = '0;
        if (det_zero8_reg)
        begin
            res_next.behind_camera   = 1'b1;
            res_next.singular_camera = 1'b1;
        end
        else
        begin
            res_next.depth           = depth8_reg;
            res_next.screen_center_x = center8_reg;
            res_next.sprite_size     = size8_reg;
            res_next.start_x         = cx_lo[17] ? 15'd0 : cx_lo[14:0];
            res_next.end_x           = (cx_hi > wm1) ? wm1[15:0] : cx_hi[15:0];
            res_next.start_y         = y_lo[17] ? 15'd0 : y_lo[14:0];
            res_next.end_y           = (y_hi > hm1) ? hm1[15:0] : y_hi[15:0];
            res_next.behind_camera   = behind8_reg;
            res_next.singular_camera = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result <= res_next;
        end
    end

endmodule

@@ tb/tb_billboard_sprite_projection.sv @@
// ----------------------------------------------------------------------------
// tb_billboard_sprite_projection
// Self-checking testbench for the billboard sprite projection block.
// Sprite items are sent in random bursts against a randomly stalling result
// side. Each accepted sprite is projected by a local model of the camera, and
// every result item is compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_billboard_sprite_projection;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = bsp_pkg::FRAC_BITS_DEF;
    localparam int PIPE_LAT = 70;

    logic                           clk;
    logic                           rst_n;
    logic                           sprite_valid;
    logic                           sprite_stall;
    bsp_pkg::sprite_t               sprite;
    logic                           result_valid;
    logic                           result_stall;
    bsp_pkg::result_t               result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bsp_pkg::CFG_DATA_W-1:0] cfg_data;

    // Camera copy used for prediction.
    logic signed [23:0] cam_px, cam_py;
    logic signed [15:0] cam_dx, cam_dy, cam_plx, cam_ply;
    logic        [12:0] cam_w, cam_h;

    bsp_pkg::result_t expected_q[$];
    int      errors;
    int      stall_pct;
    int      gap_max;
    int      burst_left;
    int      hold_reqs;
    int      hold_seen;
    int      hold_cnt;

    billboard_sprite_projection i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sprite_valid (sprite_valid),
        .sprite_stall (sprite_stall),
        .sprite       (sprite),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    function automatic bsp_pkg::result_t project_sprite(bsp_pkg::sprite_t s);
        bsp_pkg::result_t r;
        longint  sx, sy, det, nx, ny, half, dexact, depth, center, size, s2, adepth;
        longint  w, h, t;
        r      = '0;
        w      = longint'(cam_w);
        h      = longint'(cam_h);
        sx     = longint'(s.sprite_x) - longint'(cam_px);
        sy     = longint'(s.sprite_y) - longint'(cam_py);
        det    = longint'(cam_plx) * longint'(cam_dy) - longint'(cam_dx) * longint'(cam_ply);
        nx     = longint'(cam_dy) * sx - longint'(cam_dx) * sy;
        ny     = longint'(cam_plx) * sy - longint'(cam_ply) * sx;
        half   = w / 2;
        if (det == 0)
        begin
            r.behind_camera   = 1'b1;
            r.singular_camera = 1'b1;
            return r;
        end
        dexact = (ny * (longint'(1) << (30 - FRAC))) / det;
        depth  = dexact;
        if (depth > 64'sd2147483647)
            depth = 64'sd2147483647;
        if (depth < -64'sd2147483648)
            depth = -64'sd2147483648;
        if (ny == 0)
            center = half;
        else
        begin
            center = (half * (ny + nx)) / ny;
            if (center > 32767)
                center = 32767;
            if (center < -32768)
                center = -32768;
        end
        adepth = (depth < 0) ? -depth : depth;
        if (adepth == 0)
            size = 65535;
        else
        begin
            size = (h * 65536) / adepth;
            if (size > 65535)
                size = 65535;
        end
        s2 = size / 2;
        r.depth           = depth[31:0];
        r.screen_center_x = center[15:0];
        r.sprite_size     = size[15:0];
        t = (center - s2 < 0) ? 0 : center - s2;
        r.start_x         = t[14:0];
        t = (center + s2 > w - 1) ? w - 1 : center + s2;
        r.end_x           = t[15:0];
        t = (h / 2 - s2 < 0) ? 0 : h / 2 - s2;
        r.start_y         = t[14:0];
        t = (h / 2 + s2 > h - 1) ? h - 1 : h / 2 + s2;
        r.end_y           = t[15:0];
        r.behind_camera   = (dexact <= 0);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        bsp_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected item", 1, 0);
            else
            begin
                want = expected_q.pop_front();
                if (result.depth !== want.depth)
                    report_mismatch("depth", result.depth, want.depth);
                if (result.screen_center_x !== want.screen_center_x)
                    report_mismatch("screen_center_x", result.screen_center_x,
                                    want.screen_center_x);
                if (result.sprite_size !== want.sprite_size)
                    report_mismatch("sprite_size", result.sprite_size, want.sprite_size);
                if (result.start_x !== want.start_x)
                    report_mismatch("start_x", result.start_x, want.start_x);
                if (result.end_x !== want.end_x)
                    report_mismatch("end_x", result.end_x, want.end_x);
                if (result.start_y !== want.start_y)
                    report_mismatch("start_y", result.start_y, want.start_y);
                if (result.end_y !== want.end_y)
                    report_mismatch("end_y", result.end_y, want.end_y);
                if (result.behind_camera !== want.behind_camera)
                    report_mismatch("behind_camera", result.behind_camera,
                                    want.behind_camera);
                if (result.singular_camera !== want.singular_camera)
                    report_mismatch("singular_camera", result.singular_camera,
                                    want.singular_camera);
            end
        end
    end

    // Result-side stall pattern, with an occasional long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_cnt  = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_sprite(logic [23:0] x, logic [23:0] y);
        bsp_pkg::sprite_t s;
        int      gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                sprite_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        s.sprite_x = x;
        s.sprite_y = y;
        @(negedge clk);
        sprite_valid <= 1'b1;
        sprite       <= s;
        forever
        begin
            @(posedge clk);
            if (!sprite_stall)
                break;
        end
        expected_q.push_back(project_sprite(s));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        sprite_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT) @(negedge clk);
    endtask

    task automatic write_reg(logic [bsp_pkg::CFG_IDX_W-1:0] idx, logic [23:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            bsp_pkg::CFG_PLAYER_X:      cam_px  = data;
            bsp_pkg::CFG_PLAYER_Y:      cam_py  = data;
            bsp_pkg::CFG_DIR_X:         cam_dx  = data[15:0];
            bsp_pkg::CFG_DIR_Y:         cam_dy  = data[15:0];
            bsp_pkg::CFG_PLANE_X:       cam_plx = data[15:0];
            bsp_pkg::CFG_PLANE_Y:       cam_ply = data[15:0];
            bsp_pkg::CFG_SCREEN_WIDTH:  cam_w   = data[12:0];
            bsp_pkg::CFG_SCREEN_HEIGHT: cam_h   = data[12:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_camera(logic [23:0] px, logic [23:0] py, logic [15:0] dx,
                              logic [15:0] dy, logic [15:0] plx, logic [15:0] ply,
                              logic [12:0] w, logic [12:0] h);
        wait_idle();
        write_reg(bsp_pkg::CFG_PLAYER_X, px);
        write_reg(bsp_pkg::CFG_PLAYER_Y, py);
        // Upper data bits beyond the register width are driven random.
        write_reg(bsp_pkg::CFG_DIR_X, {8'($urandom_range(255)), dx});
        write_reg(bsp_pkg::CFG_DIR_Y, {8'($urandom_range(255)), dy});
        write_reg(bsp_pkg::CFG_PLANE_X, {8'($urandom_range(255)), plx});
        write_reg(bsp_pkg::CFG_PLANE_Y, {8'($urandom_range(255)), ply});
        write_reg(bsp_pkg::CFG_SCREEN_WIDTH, {11'($urandom_range(2047)), w});
        write_reg(bsp_pkg::CFG_SCREEN_HEIGHT, {11'($urandom_range(2047)), h});
    endtask

    // Sprite near the player most of the time, anywhere on the map otherwise.
    task automatic send_random_sprite();
        logic [23:0] x, y;
        if ($urandom_range(3) == 0)
        begin
            x = 24'($urandom);
            y = 24'($urandom);
        end
        else
        begin
            x = cam_px + 24'($signed($urandom_range(0, 131071)) - 65536);
            y = cam_py + 24'($signed($urandom_range(0, 131071)) - 65536);
        end
        send_sprite(x, y);
    endtask

    task automatic test_reset_camera();
        stall_pct = 0;
        gap_max   = 0;
        send_sprite(24'sd0, 24'sd0);                 // sprite on the player
        send_sprite(24'sd40960, 24'sd0);             // straight ahead
        send_sprite(-24'sd40960, 24'sd4096);         // behind the camera
        send_sprite(24'sd1, 24'sd0);                 // tiny depth
        send_sprite(24'h7fffff, 24'h7fffff);
        send_sprite(24'h800000, 24'h800000);
        send_sprite(24'h7fffff, 24'h800000);
        send_sprite(24'h800000, 24'h7fffff);
        send_sprite(24'sd4096, 24'sd40960);          // far to the side
        send_sprite(24'sd0, 24'sd4096);              // zero transformed depth
    endtask

    task automatic test_singular_camera();
        // Direction parallel to the plane gives a zero determinant.
        set_camera(24'sd0, 24'sd0, 16'sd8192, 16'sd4096, 16'sd8192, 16'sd4096,
                   13'd640, 13'd480);
        send_sprite(24'sd40960, 24'sd100);
        send_sprite(24'h800000, 24'h7fffff);
        set_camera(24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd640, 13'd480);
        send_sprite(24'sd12345, -24'sd999);
    endtask

    task automatic test_extreme_config();
        set_camera(24'h7fffff, 24'h800000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                   13'd4096, 13'd4096);
        send_sprite(24'h800000, 24'h7fffff);
        send_sprite(24'h7fffff, 24'h800000);
        set_camera(24'h800000, 24'h7fffff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                   13'd1, 13'd1);
        send_sprite(24'h7fffff, 24'h800000);
        send_sprite(24'h7ffff0, 24'h7fff00);
        // Zero screen size and sizes past the legal range.
        set_camera(24'sd0, 24'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813, 13'd0, 13'd0);
        send_sprite(24'sd40960, 24'sd0);
        set_camera(24'sd0, 24'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813,
                   13'd8191, 13'd8191);
        send_sprite(24'sd40960, 24'sd2048);
        send_sprite(24'sd8192, -24'sd2048);
        // Writes to unknown indexes must leave the camera alone.
        wait_idle();
        write_reg(4'd8, 24'hffffff);
        write_reg(4'd15, 24'h5a5a5a);
        send_sprite(24'sd20480, 24'sd1024);
    endtask

    task automatic test_backpressure();
        wait_idle();
        stall_pct = 0;
        gap_max   = 0;
        @(negedge clk);
        hold_reqs++;
        repeat (120) send_random_sprite();
        stall_pct = 30;
        gap_max   = 4;
        // Sender waits for the pipeline to empty before going on.
        wait_idle();
        repeat (20) send_random_sprite();
    endtask

    task automatic test_random_cameras();
        int          n;
        logic [15:0] dx, dy, plx, ply;
        for (int phase = 0; phase < 8; phase++)
        begin
            stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 70);
            gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
            if (phase % 2 == 0)
            begin
                dx  = 16'($urandom);
                dy  = 16'($urandom);
                plx = 16'($urandom);
                ply = 16'($urandom);
            end
            else
            begin
                dx  = 16'($signed($urandom_range(0, 32768)) - 16384);
                dy  = 16'($signed($urandom_range(0, 32768)) - 16384);
                plx = 16'(-($signed(dy) * 2 / 3));
                ply = 16'($signed(dx) * 2 / 3);
            end
            set_camera(24'($urandom), 24'($urandom), dx, dy, plx, ply,
                       13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
            n = 40;
            repeat (n) send_random_sprite();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        sprite_valid = 1'b0;
        sprite       = '0;
        result_stall = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        errors       = 0;
        stall_pct    = 0;
        gap_max      = 0;
        burst_left   = 0;
        hold_reqs    = 0;
        hold_seen    = 0;
        hold_cnt     = 0;
        cam_px       = bsp_pkg::PLAYER_X_RST;
        cam_py       = bsp_pkg::PLAYER_Y_RST;
        cam_dx       = bsp_pkg::DIR_X_RST;
        cam_dy       = bsp_pkg::DIR_Y_RST;
        cam_plx      = bsp_pkg::PLANE_X_RST;
        cam_ply      = bsp_pkg::PLANE_Y_RST;
        cam_w        = bsp_pkg::SCREEN_WIDTH_RST;
        cam_h        = bsp_pkg::SCREEN_HEIGHT_RST;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_reset_camera();
        test_singular_camera();
        test_extreme_config();
        test_backpressure();
        test_random_cameras();

        stall_pct = 20;
        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
